// File: rtl/core/md5_stream_hasher_assert.svh
// Assertion macros used by the MD5 stream hasher RTL.
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define MD5_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MD5_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 assertion failed");

`else

`define MD5_ASSERT_IMPL(label, ante, cons)
`define MD5_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/md5_pkg.sv
// Types, constants, tables and microcode ROM of the MD5 stream hasher.
package md5_pkg;

  typedef logic [3:0][31:0] md5_words_t;
  typedef logic [3:0]       pc_t;

  localparam md5_words_t CHAIN_INIT = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [5:0] POS_LEN_START = 6'd56;
  localparam logic [5:0] POS_LAST      = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [1:0] LAST_WORD     = 2'd3;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] i;
    logic [3:0] g;
    i = step[3:0];
    case (step[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'd1 + (i << 2) + i;
      2'd2:    g = 4'd5 + (i << 1) + i;
      default: g = (i << 3) - i;
    endcase
    return g;
  endfunction

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_IN,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } md5_src_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD1,
    OP_LOAD2,
    OP_ROUND,
    OP_FOLD,
    OP_EMIT
  } md5_op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_EOM,
    COND_POS56,
    COND_WRAP,
    COND_LAST_ROUND,
    COND_LAST_WORD,
    COND_RET
  } md5_cond_t;

  typedef struct packed {
    logic      in_ready;
    md5_src_t  src;
    md5_op_t   op;
    md5_cond_t cond;
    pc_t       jmp;
    pc_t       seq;
  } md5_uword_t;

  // Control of the round unit.
  typedef struct packed {
    logic       load;
    logic       seed;
    logic       step;
    logic [5:0] rnd;
  } md5_rctl_t;

  localparam pc_t P_IDLE  = 4'd0;
  localparam pc_t P_PAD80 = 4'd1;
  localparam pc_t P_PADZ  = 4'd2;
  localparam pc_t P_LEN   = 4'd3;
  localparam pc_t P_LOAD1 = 4'd4;
  localparam pc_t P_LOAD2 = 4'd5;
  localparam pc_t P_ROUND = 4'd6;
  localparam pc_t P_FOLD  = 4'd7;
  localparam pc_t P_EMIT  = 4'd8;

  // Microcode ROM. A step that writes the last byte of a block is diverted
  // to the compression program, which returns to the step's successor.
  function automatic md5_uword_t ucode(input pc_t pc);
    md5_uword_t w;
    case (pc)
      P_IDLE:  w = '{in_ready: 1'b1, src: SRC_IN, op: OP_NONE, cond: COND_EOM,
                     jmp: P_PAD80, seq: P_IDLE};
      P_PAD80: w = '{in_ready: 1'b0, src: SRC_PAD, op: OP_NONE, cond: COND_POS56,
                     jmp: P_LEN, seq: P_PADZ};
      P_PADZ:  w = '{in_ready: 1'b0, src: SRC_ZERO, op: OP_NONE, cond: COND_POS56,
                     jmp: P_LEN, seq: P_PADZ};
      P_LEN:   w = '{in_ready: 1'b0, src: SRC_LEN, op: OP_NONE, cond: COND_WRAP,
                     jmp: P_EMIT, seq: P_LEN};
      P_LOAD1: w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_LOAD1, cond: COND_NONE,
                     jmp: P_LOAD2, seq: P_LOAD2};
      P_LOAD2: w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_LOAD2, cond: COND_NONE,
                     jmp: P_ROUND, seq: P_ROUND};
      P_ROUND: w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_ROUND, cond: COND_LAST_ROUND,
                     jmp: P_FOLD, seq: P_ROUND};
      P_FOLD:  w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_FOLD, cond: COND_RET,
                     jmp: P_IDLE, seq: P_IDLE};
      P_EMIT:  w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_EMIT, cond: COND_LAST_WORD,
                     jmp: P_IDLE, seq: P_EMIT};
      default: w = '{in_ready: 1'b0, src: SRC_NONE, op: OP_NONE, cond: COND_NONE,
                     jmp: P_IDLE, seq: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/md5_channels.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface md5_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_number;
  logic        final_word;

  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

// File: rtl/core/md5_round_unit.sv
// MD5 round datapath: working words, one round step per cycle.
module md5_round_unit
  import md5_pkg::*;
(
  input  logic        clk,
  input  md5_rctl_t   ctl,
  input  md5_words_t  chain,
  input  logic [31:0] mdata,
  output md5_words_t  work
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] c;
  logic [31:0] d;
  // Holds a + K + M for the round about to run.
  logic [31:0] pre;

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [4:0]  shamt;
  logic [5:0]  kidx;
  logic [31:0] addend;
  logic [31:0] pre_next;

  always_comb begin
    case (ctl.rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum   = pre + f;
    shamt = ROT_S[{ctl.rnd[5:4], ctl.rnd[1:0]}];
    dbl   = {sum, sum} << shamt;
    // The next round's a is this round's d, so its sum is started now.
    kidx     = ctl.seed ? 6'd0 : ctl.rnd + 6'd1;
    addend   = ctl.seed ? a : d;
    pre_next = addend + ROUND_K[kidx] + mdata;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (ctl.step) begin
      a <= d;
      b <= b + dbl[63:32];
      c <= b;
      d <= c;
    end
    if (ctl.seed || ctl.step) begin
      pre <= pre_next;
    end
  end

  assign work = {d, c, b, a};

endmodule

// File: rtl/core/md5_stream_hasher.sv
// MD5 stream hasher top level: microcoded sequencer, block buffer, chaining words.
//
//   channel  dir  payload                                       accepted when
//   msg      in   msg_byte[7:0] byte_present end_of_message      msg.valid && msg.ready
//   digest   out  digest_word[31:0] word_number[1:0] final_word  digest.valid && digest.ready
//
// The 64th byte of a block detours through compression (two load steps, 64 rounds
// through the single round unit, one fold). Finishing writes up to 72 padding bytes,
// one per cycle outside compression, compressing the last block (and an extra one
// when the length spills over), then offers four words.
// Synchronous reset loads the initial chaining words and clears counters; the block
// buffer is not cleared. msg.ready is high only while the sequencer is idle, and a
// stalled digest word holds the sequencer in place.
`include "md5_stream_hasher_assert.svh"

module md5_stream_hasher
  import md5_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  md5_msg_if.sink            msg,
  md5_digest_if.source       digest
);

  pc_t        pc;
  pc_t        ret;
  md5_words_t chain;
  logic [63:0] bit_length;
  logic [5:0] pos;
  logic [5:0] rnd;
  logic [1:0] word;

  logic [31:0] blk [16];
  logic [31:0] mdata;

  md5_uword_t cw;
  md5_rctl_t  rctl;
  md5_words_t work;

  logic       in_acc;
  logic       out_acc;
  logic       put_en;
  logic [7:0] put_data;
  logic [5:0] pos_inc;
  logic       cond_true;
  pc_t        natural;
  pc_t        pc_next;
  pc_t        ret_next;
  logic [5:0] rd_idx;

  always_comb begin
    cw      = ucode(pc);
    in_acc  = msg.valid && cw.in_ready;
    out_acc = digest.valid && digest.ready;
    pos_inc = pos + 6'd1;

    case (cw.src)
      SRC_IN:   put_en = in_acc && msg.byte_present;
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN:  put_en = 1'b1;
      default:  put_en = 1'b0;
    endcase

    case (cw.src)
      SRC_IN:   put_data = msg.msg_byte;
      SRC_PAD:  put_data = PAD_BYTE;
      SRC_LEN:  put_data = bit_length[{pos[2:0], 3'b000} +: 8];
      default:  put_data = 8'h00;
    endcase

    case (cw.cond)
      COND_EOM:        cond_true = in_acc && msg.end_of_message;
      COND_POS56:      cond_true = (pos_inc == POS_LEN_START);
      COND_WRAP:       cond_true = (pos == POS_LAST);
      COND_LAST_ROUND: cond_true = (rnd == LAST_ROUND);
      COND_LAST_WORD:  cond_true = out_acc && (word == LAST_WORD);
      default:         cond_true = 1'b0;
    endcase

    if (cw.cond == COND_RET) begin
      natural = ret;
    end else if (cond_true) begin
      natural = cw.jmp;
    end else begin
      natural = cw.seq;
    end

    // A byte that fills the block detours through compression first.
    if (put_en && (pos == POS_LAST)) begin
      pc_next  = P_LOAD1;
      ret_next = natural;
    end else begin
      pc_next  = natural;
      ret_next = ret;
    end

    case (cw.op)
      OP_LOAD1: rd_idx = 6'd0;
      OP_LOAD2: rd_idx = 6'd1;
      default:  rd_idx = rnd + 6'd2;
    endcase

    rctl.load = (cw.op == OP_LOAD1);
    rctl.seed = (cw.op == OP_LOAD2);
    rctl.step = (cw.op == OP_ROUND);
    rctl.rnd  = rnd;
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= put_data;
    end
    mdata <= blk[msg_index(rd_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= P_IDLE;
      ret        <= P_IDLE;
      chain      <= CHAIN_INIT;
      bit_length <= 64'd0;
      pos        <= 6'd0;
      rnd        <= 6'd0;
      word       <= 2'd0;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
      if (put_en) begin
        pos <= pos_inc;
      end
      if (in_acc && msg.byte_present) begin
        bit_length <= bit_length + 64'd8;
      end
      if (cw.op == OP_LOAD1) begin
        rnd <= 6'd0;
      end else if (cw.op == OP_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (cw.op == OP_FOLD) begin
        for (int k = 0; k < 4; k++) begin
          chain[k] <= chain[k] + work[k];
        end
      end
      if (out_acc) begin
        word <= word + 2'd1;
        if (word == LAST_WORD) begin
          chain      <= CHAIN_INIT;
          bit_length <= 64'd0;
          pos        <= 6'd0;
        end
      end
    end
  end

  md5_round_unit u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain),
    .mdata (mdata),
    .work  (work)
  );

  assign msg.ready          = cw.in_ready;
  assign digest.valid       = (cw.op == OP_EMIT);
  assign digest.digest_word = chain[word];
  assign digest.word_number = word;
  assign digest.final_word  = (word == LAST_WORD);

  `MD5_ASSERT_IMPL(a_no_overlap, msg.ready, !digest.valid)
  `MD5_ASSERT_IMPL(a_emit_aligned, digest.valid, pos == 6'd0)
  `MD5_ASSERT_NEXT(a_rounds_end, (pc == P_ROUND) && (rnd == LAST_ROUND), pc == P_FOLD)
  `MD5_ASSERT_NEXT(a_restart, out_acc && digest.final_word, chain == CHAIN_INIT && bit_length == 64'd0)

endmodule
